### src/qwmp_pkg.sv
// shared types and constants for the quadrature weighted matrix product unit
package qwmp_pkg;

    typedef enum logic [2:0] {
        KIND_LOAD_WEIGHT = 3'd0,
        KIND_LOAD_FACE   = 3'd1,
        KIND_LOAD_DERIV  = 3'd2,
        KIND_LOAD_TARGET = 3'd3,
        KIND_COMPUTE     = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        OP_FLOW_MATRIX  = 3'd0,
        OP_CROSS_MATRIX = 3'd1,
        OP_FLOW_VECTOR  = 3'd2,
        OP_FLOW_TARGET  = 3'd3,
        OP_POWER_VECTOR = 3'd4
    } t_op;

    // mac sequencer states of the back part
    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_M1, S_M2, S_ACC, S_OUT
    } t_bst;

    typedef struct packed {
        logic [2:0]         kind;
        logic [1:0]         face;
        logic [1:0]         face_b;
        logic [2:0]         func;
        logic [3:0]         point;
        logic signed [31:0] value;
        logic [2:0]         operation;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] result_value;
        logic               last;
    } t_out_item;

    // command handed from the front part to the back part
    typedef struct packed {
        logic [2:0] operation;
        logic [1:0] face;
        logic [1:0] face_b;
    } t_cmd;

    localparam int unsigned QDEPTH = 2;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

endpackage

### src/quadrature_weighted_matrix_product_unit.sv
// per entry the mac sequencer runs S_RD, then S_M1, S_M2 and S_ACC for each point, then S_OUT
// throughput: load transactions one per cycle when no compute is queued or running; a compute
// occupies the mac sequencer for N_FUNCS^2 (matrix) or N_FUNCS (vector) entries
// a two-entry command queue takes computes while one runs; loads wait for it to finish
// reset: synchronous active low, clears control; stores are undefined until loaded
// top level of the quadrature weighted matrix product unit
module quadrature_weighted_matrix_product_unit #(
    parameter int N_FUNCS   = 4,
    parameter int N_POINTS  = 8,
    parameter int FRAC_BITS = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  qwmp_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output qwmp_pkg::t_out_item o_item
);
    import qwmp_pkg::*;

    logic      ld_en, cmd_valid, cmd_take, rdy;
    t_in_item  ld_item;
    t_cmd      cmd;

    // loads must not overtake a running or queued compute
    logic      busy;
    logic      front_valid;
    assign front_valid = i_valid && !(busy && i_item.kind != KIND_COMPUTE);
    assign o_ready = rdy && !(busy && i_item.kind != KIND_COMPUTE);

    qwmp_front #(.N_FUNCS(N_FUNCS), .N_POINTS(N_POINTS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(front_valid), .o_ready(rdy),
        .i_item(i_item), .o_ld_en(ld_en), .o_ld_item(ld_item),
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_take(cmd_take));

    qwmp_back #(.N_FUNCS(N_FUNCS), .N_POINTS(N_POINTS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ld_en(ld_en), .i_ld_item(ld_item),
        .i_cmd_valid(cmd_valid), .i_cmd(cmd), .o_cmd_take(cmd_take),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item));

    // computes taken by the back part whose last entry has not yet left
    logic [1:0] r_run, n_run;
    always_comb begin
        n_run = r_run + 2'(cmd_take) - 2'(o_valid && i_ready && o_item.last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else begin
            r_run <= n_run;
        end
    end
    assign busy = (r_run != 2'd0) || cmd_valid;

    a_no_load_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_en |-> !cmd_valid) else $error("load during queued compute");
    a_take_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |-> cmd_valid) else $error("command taken from empty queue");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item)) else $error("output dropped");
endmodule

### src/qwmp_ram.sv
// generic single-port-write, registered-read ram
module qwmp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### src/qwmp_front.sv
// front part: accepts items, performs loads, queues compute commands
module qwmp_front #(
    parameter int N_FUNCS  = 4,
    parameter int N_POINTS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  qwmp_pkg::t_in_item i_item,
    output logic               o_ld_en,
    output qwmp_pkg::t_in_item o_ld_item,
    output logic               o_cmd_valid,
    output qwmp_pkg::t_cmd     o_cmd,
    input  logic               i_cmd_take
);
    import qwmp_pkg::*;

    t_cmd       r_q [QDEPTH];
    logic [1:0] r_cnt, n_cnt;
    logic       r_rd, r_wr;
    logic       push, pop, is_cmd, load_ok;

    always_comb begin
        is_cmd = (i_item.kind == KIND_COMPUTE) && (i_item.operation <= OP_POWER_VECTOR);
        load_ok = (i_item.kind <= KIND_LOAD_TARGET)
                  && ({28'd0, i_item.point} < N_POINTS)
                  && (i_item.kind == KIND_LOAD_WEIGHT || i_item.kind == KIND_LOAD_TARGET
                      || {29'd0, i_item.func} < N_FUNCS);
    end

    assign o_ready     = (r_cnt != 2'(QDEPTH));
    assign push        = i_valid && o_ready && is_cmd;
    assign pop         = i_cmd_take && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign o_ld_en     = i_valid && o_ready && load_ok;
    assign o_ld_item   = i_item;

    always_comb begin
        n_cnt = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
        end
        if (push) begin
            r_q[r_wr] <= '{operation: i_item.operation, face: i_item.face,
                           face_b: i_item.face_b};
        end
    end
endmodule

### src/qwmp_back.sv
// back part: stores and a mac sequencer that emits one entry per sum
module qwmp_back #(
    parameter int N_FUNCS   = 4,
    parameter int N_POINTS  = 8,
    parameter int FRAC_BITS = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ld_en,
    input  qwmp_pkg::t_in_item  i_ld_item,
    input  logic                i_cmd_valid,
    input  qwmp_pkg::t_cmd      i_cmd,
    output logic                o_cmd_take,
    output logic                o_valid,
    input  logic                i_ready,
    output qwmp_pkg::t_out_item o_item
);
    import qwmp_pkg::*;

    localparam int FW  = (N_FUNCS > 1) ? $clog2(N_FUNCS) : 1;
    localparam int PW  = (N_POINTS > 1) ? $clog2(N_POINTS) : 1;
    localparam int FD  = 1 << FW;
    localparam int PD  = 1 << PW;
    localparam int FAW = 2 + FW + PW;
    localparam int DAW = FW + PW;

    t_bst            r_st, n_st;
    t_cmd            r_cmd;
    logic [FW-1:0]   r_i, r_j;
    logic [PW-1:0]   r_k;
    logic            r_kdone;
    logic signed [63:0] r_sum, r_p;
    logic signed [31:0] r_a, r_b, r_c;
    logic            r_ov;
    t_out_item       r_out;

    // store write ports
    logic we_w, we_f, we_d, we_t;
    assign we_w = i_ld_en && i_ld_item.kind == KIND_LOAD_WEIGHT;
    assign we_f = i_ld_en && i_ld_item.kind == KIND_LOAD_FACE;
    assign we_d = i_ld_en && i_ld_item.kind == KIND_LOAD_DERIV;
    assign we_t = i_ld_en && i_ld_item.kind == KIND_LOAD_TARGET;

    logic [PW-1:0]  ld_p;
    logic [FW-1:0]  ld_f;
    assign ld_p = i_ld_item.point[PW-1:0];
    assign ld_f = i_ld_item.func[FW-1:0];

    logic [31:0] w_rd, fa_rd, fb_rd, d_rd, t_rd;
    logic [FAW-1:0] fa_ra, fb_ra;
    logic [DAW-1:0] d_ra;
    logic [FW-1:0]  fb_row;
    // flow vector ops use the row index for the derivative
    assign fb_row = r_j;
    assign fa_ra  = {r_cmd.face, r_i, r_k};
    assign fb_ra  = {r_cmd.face_b, fb_row, r_k};
    assign d_ra   = (r_cmd.operation >= OP_FLOW_VECTOR) ? {r_i, r_k} : {r_j, r_k};

    qwmp_ram #(.WIDTH(32), .DEPTH(PD)) u_w (.i_clk(i_clk), .i_we(we_w), .i_waddr(ld_p),
        .i_wdata(i_ld_item.value), .i_raddr(r_k), .o_rdata(w_rd));
    qwmp_ram #(.WIDTH(32), .DEPTH(PD)) u_t (.i_clk(i_clk), .i_we(we_t), .i_waddr(ld_p),
        .i_wdata(i_ld_item.value), .i_raddr(r_k), .o_rdata(t_rd));
    qwmp_ram #(.WIDTH(32), .DEPTH(4*FD*PD)) u_fa (.i_clk(i_clk), .i_we(we_f),
        .i_waddr({i_ld_item.face, ld_f, ld_p}), .i_wdata(i_ld_item.value),
        .i_raddr(fa_ra), .o_rdata(fa_rd));
    qwmp_ram #(.WIDTH(32), .DEPTH(4*FD*PD)) u_fb (.i_clk(i_clk), .i_we(we_f),
        .i_waddr({i_ld_item.face, ld_f, ld_p}), .i_wdata(i_ld_item.value),
        .i_raddr(fb_ra), .o_rdata(fb_rd));
    qwmp_ram #(.WIDTH(32), .DEPTH(FD*PD)) u_d (.i_clk(i_clk), .i_we(we_d),
        .i_waddr({ld_f, ld_p}), .i_wdata(i_ld_item.value),
        .i_raddr(d_ra), .o_rdata(d_rd));

    logic is_mat, two_fac, last_k, last_j, last_i;
    assign is_mat  = r_cmd.operation <= OP_CROSS_MATRIX;
    assign two_fac = r_cmd.operation == OP_FLOW_VECTOR;
    assign last_k  = {{(32-PW){1'b0}}, r_k} == N_POINTS - 1;
    assign last_j  = !is_mat || {{(32-FW){1'b0}}, r_j} == N_FUNCS - 1;
    assign last_i  = {{(32-FW){1'b0}}, r_i} == N_FUNCS - 1;

    logic signed [63:0] prod, q, sum_n;
    logic signed [31:0] q32;
    always_comb begin
        prod  = r_a * r_b;
        q     = prod >>> FRAC_BITS;
        q32   = sat32(q);
        sum_n = r_sum + r_p;
    end

    always_comb begin
        n_st = r_st;
        o_cmd_take = 1'b0;
        case (r_st)
            S_IDLE:  if (i_cmd_valid) begin n_st = S_RD; o_cmd_take = 1'b1; end
            S_RD:    n_st = S_M1;
            S_M1:    n_st = S_M2;
            S_M2:    n_st = S_ACC;
            S_ACC:   n_st = r_kdone ? S_OUT : S_M1;
            S_OUT:   if (!r_ov || i_ready) n_st = (last_i && last_j) ? S_IDLE : S_RD;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == S_OUT && (!r_ov || i_ready)) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
        case (r_st)
            S_IDLE: begin
                r_cmd <= i_cmd;
                r_i <= '0; r_j <= '0; r_k <= '0; r_sum <= '0;
            end
            S_RD: ;
            S_M1: begin
                // stage one operands from the registered reads
                r_a <= w_rd;
                case (r_cmd.operation)
                    OP_FLOW_MATRIX:  begin r_b <= fa_rd; r_c <= d_rd;  end
                    OP_CROSS_MATRIX: begin r_b <= fa_rd; r_c <= fb_rd; end
                    OP_FLOW_VECTOR:  begin r_b <= d_rd;  r_c <= d_rd;  end
                    OP_FLOW_TARGET:  begin r_b <= t_rd;  r_c <= d_rd;  end
                    default:         begin r_b <= fa_rd; r_c <= t_rd;  end
                endcase
                // remember whether this point is the final one of the sum
                r_kdone <= last_k;
                if (!last_k) r_k <= r_k + 1'b1;
            end
            S_M2: begin
                if (two_fac) begin
                    r_p <= q;
                    r_a <= 32'sd0;
                end else begin
                    r_a <= q32;
                    r_b <= r_c;
                end
            end
            S_ACC: begin
                r_sum <= sum_n + (two_fac ? 64'sd0 : q);
            end
            S_OUT: begin
                if (!r_ov || i_ready) begin
                    r_out <= '{row: 3'(r_i), col: is_mat ? 3'(r_j) : 3'd0,
                               result_value: sat32(r_sum), last: last_i && last_j};
                    r_sum <= '0;
                    r_k   <= '0;
                    if (last_j) begin
                        r_j <= '0;
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (r_st == S_M1) r_p <= '0;
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;
endmodule
